// ----- rtl/rtd_three_wire_resistance_history_assert.svh -----
// Assertion shorthands for the RTD history checks.
// Each expects clk and rst_n in scope.
`ifndef RTD_THREE_WIRE_RESISTANCE_HISTORY_ASSERT_SVH
`define RTD_THREE_WIRE_RESISTANCE_HISTORY_ASSERT_SVH

// Same-cycle implication.
`define RTDH_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rtdh check failed");

// Next-cycle implication.
`define RTDH_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rtdh check failed");

`endif

// ----- rtl/rtdh_pkg.sv -----
`default_nettype none

package rtdh_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int MAX_RESULTS   = 16;

    localparam int CODE_W   = 16;
    localparam int CNT_W    = 5;
    localparam int RES_W    = 24;
    localparam int SERIES_W = 20;
    localparam int MINREF_W = 15;
    localparam int NUM_W    = 15;
    localparam int PROD_W   = SERIES_W + NUM_W;
    localparam int STEP_W   = $clog2(PROD_W + 1);
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [SERIES_W-1:0] SERIES_RESET = 20'd16000;
    localparam logic [MINREF_W-1:0] MINREF_RESET = 15'd1;
    localparam logic [RES_W-1:0]    RES_MAX      = '1;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic REG_SERIES = 1'b0;
    localparam logic REG_MINREF = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [CODE_W-1:0] ref_code;
        logic signed [CODE_W-1:0] cable_code;
        logic signed [CODE_W-1:0] sensor_code;
        logic [CNT_W-1:0]         read_count;
    } item_t;

    typedef struct packed {
        logic [RES_W-1:0] resistance_x16;
        logic             value_valid;
        logic             request_ok;
        logic             last;
    } result_t;

    typedef struct packed {
        logic             ok;
        logic [RES_W-1:0] value;
    } hist_entry_t;

    typedef struct packed {
        logic        en;
        hist_entry_t entry;
    } hist_wr_t;

    typedef struct packed {
        logic                start;
        logic [SERIES_W-1:0] series;
        logic [NUM_W-1:0]    num;
        logic [CODE_W-1:0]   divisor;
    } arith_req_t;

endpackage

`default_nettype wire

// ----- rtl/rtdh_arith.sv -----
`default_nettype none

module rtdh_arith (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rtdh_pkg::arith_req_t              req,
    output logic                                   done,
    output logic [rtdh_pkg::RES_W-1:0]             quotient
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_DONE
    } arith_state_t;

    arith_state_t                      state_reg, state_next;
    logic [rtdh_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [rtdh_pkg::PROD_W:0]         data_reg, data_next;
    logic [rtdh_pkg::CODE_W-1:0]       rem_reg, rem_next;
    logic [rtdh_pkg::SERIES_W-1:0]     series_reg, series_next;
    logic [rtdh_pkg::CODE_W-1:0]       div_reg, div_next;
    logic                              done_reg, done_next;
    logic [rtdh_pkg::RES_W-1:0]        quot_reg, quot_next;

    logic [rtdh_pkg::SERIES_W:0]       mul_sum;
    logic [rtdh_pkg::CODE_W:0]         shifted;
    logic [rtdh_pkg::CODE_W+1:0]       diff;
    logic                              qbit;

    // Shift-add multiply: upper part accumulates, multiplier bits leave at the bottom.
    assign mul_sum = data_reg[rtdh_pkg::PROD_W:rtdh_pkg::NUM_W]
                   + (data_reg[0] ? {1'b0, series_reg} : '0);

    // Restoring divide: one quotient bit a cycle, shifted into the dividend register.
    assign shifted = {rem_reg, data_reg[rtdh_pkg::PROD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign qbit    = !diff[rtdh_pkg::CODE_W+1];

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        data_next   = data_reg;
        rem_next    = rem_reg;
        series_next = series_reg;
        div_next    = div_reg;
        done_next   = 1'b0;
        quot_next   = quot_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    data_next   = {{(rtdh_pkg::SERIES_W + 1){1'b0}}, req.num};
                    series_next = req.series;
                    div_next    = req.divisor;
                    rem_next    = '0;
                    step_next   = '0;
                    state_next  = A_MUL;
                end
            end
            A_MUL:
            begin
                data_next = {1'b0, mul_sum, data_reg[rtdh_pkg::NUM_W-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == rtdh_pkg::STEP_W'(rtdh_pkg::NUM_W - 1))
                begin
                    step_next  = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                data_next = {1'b0, data_reg[rtdh_pkg::PROD_W-2:0], qbit};
                rem_next  = qbit ? diff[rtdh_pkg::CODE_W-1:0]
                                 : shifted[rtdh_pkg::CODE_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == rtdh_pkg::STEP_W'(rtdh_pkg::PROD_W - 1))
                begin
                    state_next = A_DONE;
                end
            end
            A_DONE:
            begin
                done_next  = 1'b1;
                // saturate: any quotient bit above the result width pins to max
                quot_next  = (|data_reg[rtdh_pkg::PROD_W-1:rtdh_pkg::RES_W])
                           ? rtdh_pkg::RES_MAX : data_reg[rtdh_pkg::RES_W-1:0];
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        rem_reg    <= rem_next;
        series_reg <= series_next;
        div_reg    <= div_next;
        quot_reg   <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/rtdh_history.sv -----
`default_nettype none

module rtdh_history (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rtdh_pkg::hist_wr_t            wr,
    input  wire logic [rtdh_pkg::PTR_W-1:0]    rd_addr,
    output rtdh_pkg::hist_entry_t              rd_entry,
    output logic [rtdh_pkg::PTR_W-1:0]         head
);

    rtdh_pkg::hist_entry_t             mem_reg [rtdh_pkg::HISTORY_DEPTH];
    logic [rtdh_pkg::PTR_W-1:0]        head_reg, head_next;

    assign head_next = (head_reg == rtdh_pkg::PTR_W'(rtdh_pkg::HISTORY_DEPTH - 1))
                     ? '0 : head_reg + 1'b1;

    // Reset leaves every entry at zero and marked valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rtdh_pkg::HISTORY_DEPTH; i++)
            begin
                mem_reg[i].ok    <= 1'b1;
                mem_reg[i].value <= '0;
            end
            head_reg <= '0;
        end
        else if (wr.en)
        begin
            mem_reg[head_reg] <= wr.entry;
            head_reg          <= head_next;
        end
    end

    assign rd_entry = mem_reg[rd_addr];
    assign head     = head_reg;

endmodule

`default_nettype wire

// ----- rtl/rtd_three_wire_resistance_history.sv -----
`default_nettype none

// Three-wire RTD resistance with a ring history. A measure beat computes
// series_ohms_x16 * (sensor - 2*|cable|) / |ref| in 1/16 ohm, truncated and
// saturated to 24 bits, and stores it with a valid flag; it returns nothing.
// A measure beat that fails a check (series zero, |ref| zero or below
// min_ref_code, negative numerator) is stored as soon as it is accepted. One
// that passes runs through a bit-serial shift-add multiplier (one numerator
// bit per cycle) and a restoring divider (one quotient bit per cycle), and
// the next item is taken only once its result is stored. A read beat of
// count N emits N result beats, oldest first, one per cycle while
// result_ready is high, and the next item is taken after the last beat is
// loaded; an invalid count gives one rejected beat. The history is cleared
// directly by reset, with no clearing pass. Registers: series_ohms_x16 at
// 0x0, min_ref_code at 0x4; write them only while the block is idle.
module rtd_three_wire_resistance_history (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire rtdh_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output rtdh_pkg::result_t                   result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rtdh_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rtdh_pkg::DATA_W-1:0]    pwdata,
    output logic [rtdh_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int SW = rtdh_pkg::PTR_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } top_state_t;

    top_state_t                          state_reg, state_next;
    logic [rtdh_pkg::PTR_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [rtdh_pkg::CNT_W-1:0]          left_reg, left_next;
    logic                                rej_reg, rej_next;
    logic                                res_valid_reg, res_valid_next;
    rtdh_pkg::result_t                   res_reg, res_next;
    logic [rtdh_pkg::SERIES_W-1:0]       series_reg;
    logic [rtdh_pkg::MINREF_W-1:0]       minref_reg;

    logic                                cfg_wr;
    logic                                reg_idx;
    logic [rtdh_pkg::CODE_W-1:0]         ref_bits, cab_bits;
    logic [rtdh_pkg::CODE_W-1:0]         ref_mag, cab_mag;
    logic [rtdh_pkg::CODE_W+1:0]         num;
    logic                                pre_ok;
    logic                                count_ok;
    logic [SW-1:0]                       start_sum;
    logic [rtdh_pkg::PTR_W-1:0]          start_idx;
    logic [rtdh_pkg::PTR_W-1:0]          rd_idx_inc;
    logic                                accept;
    logic                                slot_free;

    rtdh_pkg::arith_req_t                arith_req;
    logic                                arith_done;
    logic [rtdh_pkg::RES_W-1:0]          arith_q;
    rtdh_pkg::hist_wr_t                  hist_wr;
    rtdh_pkg::hist_entry_t               rd_entry;
    logic [rtdh_pkg::PTR_W-1:0]          head;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[rtdh_pkg::ADDR_W-1];
    assign prdata  = (reg_idx == rtdh_pkg::REG_MINREF)
                   ? {{(rtdh_pkg::DATA_W - rtdh_pkg::MINREF_W){1'b0}}, minref_reg}
                   : {{(rtdh_pkg::DATA_W - rtdh_pkg::SERIES_W){1'b0}}, series_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg <= rtdh_pkg::SERIES_RESET;
            minref_reg <= rtdh_pkg::MINREF_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == rtdh_pkg::REG_MINREF)
            begin
                minref_reg <= pwdata[rtdh_pkg::MINREF_W-1:0];
            end
            else
            begin
                series_reg <= pwdata[rtdh_pkg::SERIES_W-1:0];
            end
        end
    end

    // measurement checks
    assign ref_bits = item.ref_code;
    assign cab_bits = item.cable_code;
    assign ref_mag  = ref_bits[rtdh_pkg::CODE_W-1] ? ('0 - ref_bits) : ref_bits;
    assign cab_mag  = cab_bits[rtdh_pkg::CODE_W-1] ? ('0 - cab_bits) : cab_bits;
    assign num      = {{2{item.sensor_code[rtdh_pkg::CODE_W-1]}}, item.sensor_code}
                    - {1'b0, cab_mag, 1'b0};
    assign pre_ok   = (series_reg != '0) && (ref_mag != '0)
                   && (ref_mag >= {1'b0, minref_reg}) && !num[rtdh_pkg::CODE_W+1];

    // read window: start at head - count, wrapping around the ring
    assign count_ok  = (item.read_count != '0)
                    && (32'(item.read_count) <= rtdh_pkg::HISTORY_DEPTH)
                    && (32'(item.read_count) <= rtdh_pkg::MAX_RESULTS);
    assign start_sum = {1'b0, head} + SW'(rtdh_pkg::HISTORY_DEPTH)
                     - SW'(item.read_count);
    assign start_idx = (start_sum >= SW'(rtdh_pkg::HISTORY_DEPTH))
                     ? rtdh_pkg::PTR_W'(start_sum - SW'(rtdh_pkg::HISTORY_DEPTH))
                     : start_sum[rtdh_pkg::PTR_W-1:0];
    assign rd_idx_inc = (rd_idx_reg == rtdh_pkg::PTR_W'(rtdh_pkg::HISTORY_DEPTH - 1))
                      ? '0 : rd_idx_reg + 1'b1;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign slot_free  = !res_valid_reg || result_ready;

    assign arith_req.start   = accept && (item.op == rtdh_pkg::OP_MEASURE) && pre_ok;
    assign arith_req.series  = series_reg;
    assign arith_req.num     = num[rtdh_pkg::NUM_W-1:0];
    assign arith_req.divisor = ref_mag;

    // failed checks store at once; passing measurements store when the divider finishes
    assign hist_wr.en          = (accept && (item.op == rtdh_pkg::OP_MEASURE) && !pre_ok)
                              || arith_done;
    assign hist_wr.entry.ok    = arith_done;
    assign hist_wr.entry.value = arith_done ? arith_q : '0;

    rtdh_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (arith_req),
        .done     (arith_done),
        .quotient (arith_q)
    );

    rtdh_history u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (hist_wr),
        .rd_addr  (rd_idx_reg),
        .rd_entry (rd_entry),
        .head     (head)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        left_next      = left_reg;
        rej_next       = rej_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == rtdh_pkg::OP_READ)
                    begin
                        rej_next    = !count_ok;
                        rd_idx_next = start_idx;
                        left_next   = item.read_count;
                        state_next  = ST_EMIT;
                    end
                    else if (pre_ok)
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (arith_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    if (rej_reg)
                    begin
                        res_next.resistance_x16 = '0;
                        res_next.value_valid    = 1'b0;
                        res_next.request_ok     = 1'b0;
                        res_next.last           = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        res_next.resistance_x16 = rd_entry.value;
                        res_next.value_valid    = rd_entry.ok;
                        res_next.request_ok     = 1'b1;
                        res_next.last           = (left_reg == rtdh_pkg::CNT_W'(1));
                        rd_idx_next             = rd_idx_inc;
                        left_next               = left_reg - 1'b1;
                        if (left_reg == rtdh_pkg::CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            rej_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            rej_reg       <= rej_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ----- rtl/rtdh_checker.sv -----
`default_nettype none

`include "rtd_three_wire_resistance_history_assert.svh"

module rtdh_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    input  wire logic                           item_ready,
    input  wire rtdh_pkg::item_t                item,
    input  wire logic                           result_valid,
    input  wire logic                           result_ready,
    input  wire rtdh_pkg::result_t              result
);

    logic rejected;
    logic invalid_entry;
    logic res_zero;
    logic read_accept;

    assign rejected      = result_valid && !result.request_ok;
    assign invalid_entry = result_valid && result.request_ok && !result.value_valid;
    assign res_zero      = (result.resistance_x16 == '0);
    assign read_accept   = item_valid && item_ready && (item.op == rtdh_pkg::OP_READ);

    // hold a stalled beat
    `RTDH_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // a rejected read is a single, empty, final beat
    `RTDH_ASSERT_SAME(a_reject_shape, rejected, result.last && !result.value_valid && res_zero)

    // invalid measurements are stored as zero
    `RTDH_ASSERT_SAME(a_invalid_zero, invalid_entry, res_zero)

    // a read blocks the input until its beats are issued
    `RTDH_ASSERT_NEXT(a_read_blocks, read_accept, !item_ready)

endmodule

bind rtd_three_wire_resistance_history rtdh_checker u_rtdh_checker (.*);

`default_nettype wire
